// File: hw/rtl/gpcg_pkg.sv
package gpcg_pkg;

    // area sizes above this saturate
    localparam int MAX_SIZE = 4096;

    localparam int SZ_W    = 13;
    localparam int COORD_W = 12;
    localparam int COLOR_W = 24;
    localparam int CH_W    = 8;
    localparam int ADDR_W  = 3;

    // position t in unsigned q0.16, one extra bit for 1.0
    localparam int T_W = 17;
    localparam logic [T_W-1:0] T_ONE = T_W'(65536);

    // divider and square root widths
    localparam int DEN_W  = 26;
    localparam int DSQ_W  = 28;
    localparam int Q_W    = 32;
    localparam int ROOT_W = 16;
    localparam int SREM_W = 18;

    localparam logic [SZ_W-1:0] SIZE_MAX = SZ_W'(MAX_SIZE);

    typedef enum logic [1:0] {
        MODE_ROW    = 2'd0,
        MODE_COL    = 2'd1,
        MODE_RADIAL = 2'd2,
        MODE_DIAG   = 2'd3
    } t_mode;

    // configuration register indexes
    localparam logic [ADDR_W-1:0] REG_MODE   = 3'd0;
    localparam logic [ADDR_W-1:0] REG_START  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_END    = 3'd2;
    localparam logic [ADDR_W-1:0] REG_WIDTH  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_HEIGHT = 3'd4;

    // per-item control flags carried down the pipe
    typedef struct packed {
        logic radial;
        logic sat;
        logic zero;
    } t_ctl;

endpackage

// File: hw/rtl/gradient_pixel_color_generator_top.sv
// gradient pixel color generator
// input stream: one pixel coordinate per transfer, tdata = {row, col}.
// output stream: one color per transfer, tdata = {blue, green, red}.
// the configuration port writes mode, start color, end color, area width
// and area height; write only while no pixel is in flight.
// from input transfer to output valid a pixel passes 3 front-end
// stages, 32 stages of the restoring divider, 16 stages of the square
// root and 3 blend stages ending in the output register.
// throughput is one pixel per clock unless stalled; every stage is registered.
// when the receiver stalls the whole pipe holds and input tready drops,
// so nothing is lost or repeated; a waiting output does not block the
// input while the output register is empty or being taken.
// reset clears all valid bits and loads the default registers: by-row
// mode, black to white, 80 by 25 area.
module gradient_pixel_color_generator_top
    import gpcg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [23:0]         i_s_axis_tdata,   // col[11:0], row[23:12]
    // output stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    output logic [23:0]         o_m_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [ADDR_W-1:0]   i_cfg_addr,
    input  logic [COLOR_W-1:0]  i_cfg_data
);

    // configuration registers
    t_mode               r_mode;
    logic [COLOR_W-1:0]  r_start, r_end;
    logic [SZ_W-1:0]     r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ROW;
            r_start  <= '0;
            r_end    <= 24'hFFFFFF;
            r_width  <= SZ_W'(80);
            r_height <= SZ_W'(25);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_MODE:   r_mode   <= t_mode'(i_cfg_data[1:0]);
                REG_START:  r_start  <= i_cfg_data;
                REG_END:    r_end    <= i_cfg_data;
                REG_WIDTH:  r_width  <= i_cfg_data[SZ_W-1:0];
                REG_HEIGHT: r_height <= i_cfg_data[SZ_W-1:0];
                default:    ;
            endcase
        end
    end

    // pipe advances unless a finished color waits on a stalled receiver
    logic ce;
    assign ce              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = ce;

    logic               f_valid;
    t_ctl               f_ctl;
    logic [DEN_W-1:0]   f_num, f_den;
    logic               d_valid;
    t_ctl               d_ctl;
    logic [Q_W-1:0]     d_quot;
    logic               s_valid;
    t_ctl               s_ctl;
    logic [ROOT_W-1:0]  s_root, s_lin;

    gpcg_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ce     (ce),
        .i_valid  (i_s_axis_tvalid),
        .i_col    (i_s_axis_tdata[11:0]),
        .i_row    (i_s_axis_tdata[23:12]),
        .i_mode   (r_mode),
        .i_width  (r_width),
        .i_height (r_height),
        .o_valid  (f_valid),
        .o_ctl    (f_ctl),
        .o_num    (f_num),
        .o_den    (f_den)
    );

    gpcg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (f_valid),
        .i_ctl   (f_ctl),
        .i_num   (f_num),
        .i_den   (f_den),
        .o_valid (d_valid),
        .o_ctl   (d_ctl),
        .o_quot  (d_quot)
    );

    gpcg_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (d_valid),
        .i_ctl   (d_ctl),
        .i_quot  (d_quot),
        .o_valid (s_valid),
        .o_ctl   (s_ctl),
        .o_root  (s_root),
        .o_lin   (s_lin)
    );

    gpcg_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_valid (s_valid),
        .i_ctl   (s_ctl),
        .i_root  (s_root),
        .i_lin   (s_lin),
        .i_start (r_start),
        .i_end   (r_end),
        .o_valid (o_m_axis_tvalid),
        .o_rgb   (o_m_axis_tdata)
    );

endmodule

// File: hw/rtl/gpcg_front.sv
module gpcg_front
    import gpcg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  logic                i_valid,
    input  logic [COORD_W-1:0]  i_col,
    input  logic [COORD_W-1:0]  i_row,
    input  t_mode               i_mode,
    input  logic [SZ_W-1:0]     i_width,
    input  logic [SZ_W-1:0]     i_height,
    output logic                o_valid,
    output t_ctl                o_ctl,
    output logic [DEN_W-1:0]    o_num,
    output logic [DEN_W-1:0]    o_den
);

    // stage 1: saturate size, linear ratio operands, doubled offsets
    logic [SZ_W-1:0]       w, h;
    logic [SZ_W:0]         wh_sum;
    logic [SZ_W-1:0]       lin_num, lin_den;
    logic                  lin_zero;
    logic signed [14:0]    dx, dy;

    logic                  r1_valid;
    logic                  r1_radial, r1_zero;
    logic [SZ_W-1:0]       r1_num, r1_den, r1_w, r1_h;
    logic signed [14:0]    r1_dx, r1_dy;

    assign w      = (i_width  > SIZE_MAX) ? SIZE_MAX : i_width;
    assign h      = (i_height > SIZE_MAX) ? SIZE_MAX : i_height;
    assign wh_sum = {1'b0, w} + {1'b0, h};
    assign dx     = $signed({2'b00, i_col, 1'b0}) - $signed({2'b00, w});
    assign dy     = $signed({2'b00, i_row, 1'b0}) - $signed({2'b00, h});

    always_comb begin
        lin_num  = '0;
        lin_den  = '0;
        lin_zero = 1'b0;
        case (i_mode)
            MODE_ROW: begin
                lin_num  = {1'b0, i_row};
                lin_den  = h - SZ_W'(1);
                lin_zero = (h <= SZ_W'(1));
            end
            MODE_COL: begin
                lin_num  = {1'b0, i_col};
                lin_den  = w - SZ_W'(1);
                lin_zero = (w <= SZ_W'(1));
            end
            MODE_DIAG: begin
                lin_num  = {1'b0, i_col} + {1'b0, i_row};
                lin_den  = SZ_W'(wh_sum - (SZ_W+1)'(2));
                lin_zero = (wh_sum <= (SZ_W+1)'(2));
            end
            default: begin
                lin_num  = '0;
                lin_den  = '0;
                lin_zero = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_ce) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_radial <= (i_mode == MODE_RADIAL);
            r1_zero   <= lin_zero;
            r1_num    <= lin_num;
            r1_den    <= lin_den;
            r1_w      <= w;
            r1_h      <= h;
            r1_dx     <= dx;
            r1_dy     <= dy;
        end
    end

    // stage 2: squares for the radial distance and corner distance
    logic signed [29:0]    dx_sq, dy_sq;
    logic [2*SZ_W-1:0]     w_sq, h_sq;

    logic                  r2_valid;
    logic                  r2_radial, r2_zero;
    logic [SZ_W-1:0]       r2_num, r2_den;
    logic [DSQ_W-1:0]      r2_dx2, r2_dy2;
    logic [DEN_W-1:0]      r2_w2, r2_h2;

    assign dx_sq = r1_dx * r1_dx;
    assign dy_sq = r1_dy * r1_dy;
    assign w_sq  = r1_w * r1_w;
    assign h_sq  = r1_h * r1_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_ce) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r2_radial <= r1_radial;
            r2_zero   <= r1_zero;
            r2_num    <= r1_num;
            r2_den    <= r1_den;
            r2_dx2    <= dx_sq[DSQ_W-1:0];
            r2_dy2    <= dy_sq[DSQ_W-1:0];
            r2_w2     <= w_sq;
            r2_h2     <= h_sq;
        end
    end

    // stage 3: pick dividend and divisor, flag clamp and zero divisor
    logic [DSQ_W-1:0]  d_sum;
    logic [DEN_W-1:0]  m_sum;
    t_ctl              ctl;
    logic [DEN_W-1:0]  num, den;

    logic              r3_valid;
    t_ctl              r3_ctl;
    logic [DEN_W-1:0]  r3_num, r3_den;

    assign d_sum = r2_dx2 + r2_dy2;
    assign m_sum = r2_w2 + r2_h2;

    always_comb begin
        ctl.radial = r2_radial;
        if (r2_radial) begin
            ctl.zero = (m_sum == '0);
            ctl.sat  = (m_sum != '0) && (d_sum >= {2'b00, m_sum});
            den      = m_sum;
            num      = d_sum[DEN_W-1:0];
        end else begin
            ctl.zero = r2_zero;
            ctl.sat  = !r2_zero && (r2_num >= r2_den);
            den      = DEN_W'(r2_den);
            num      = DEN_W'(r2_num);
        end
        if (ctl.zero || ctl.sat) begin
            num = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_ce) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r3_ctl <= ctl;
            r3_num <= num;
            r3_den <= den;
        end
    end

    assign o_valid = r3_valid;
    assign o_ctl   = r3_ctl;
    assign o_num   = r3_num;
    assign o_den   = r3_den;

endmodule

// File: hw/rtl/gpcg_div.sv
module gpcg_div
    import gpcg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_ce,
    input  logic              i_valid,
    input  t_ctl              i_ctl,
    input  logic [DEN_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_valid,
    output t_ctl              o_ctl,
    output logic [Q_W-1:0]    o_quot
);

    // restoring division, one quotient bit per stage, num below den
    logic              r_vld [Q_W];
    t_ctl              r_ctl [Q_W];
    logic [DEN_W-1:0]  r_rem [Q_W];
    logic [DEN_W-1:0]  r_den [Q_W];
    logic [Q_W-1:0]    r_q   [Q_W];

    for (genvar g = 0; g < Q_W; g++) begin : g_stage
        logic              p_vld;
        t_ctl              p_ctl;
        logic [DEN_W-1:0]  p_rem, p_den;
        logic [Q_W-1:0]    p_q;
        logic [DEN_W:0]    sh, diff;
        logic              ge;

        if (g == 0) begin : g_first
            assign p_vld = i_valid;
            assign p_ctl = i_ctl;
            assign p_rem = i_num;
            assign p_den = i_den;
            assign p_q   = '0;
        end else begin : g_next
            assign p_vld = r_vld[g-1];
            assign p_ctl = r_ctl[g-1];
            assign p_rem = r_rem[g-1];
            assign p_den = r_den[g-1];
            assign p_q   = r_q[g-1];
        end

        assign sh   = {p_rem, 1'b0};
        assign ge   = (sh >= {1'b0, p_den});
        assign diff = sh - {1'b0, p_den};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_ce) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_ctl[g] <= p_ctl;
                r_den[g] <= p_den;
                r_rem[g] <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
                r_q[g]   <= {p_q[Q_W-2:0], ge};
            end
        end
    end

    assign o_valid = r_vld[Q_W-1];
    assign o_ctl   = r_ctl[Q_W-1];
    assign o_quot  = r_q[Q_W-1];

    // front end hands over a proper fraction unless the divisor is zero
    a_num_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ctl.zero) |-> (i_num < i_den))
        else $error("dividend not below divisor");

    // remainder leaving the last stage stays below the divisor
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[Q_W-1] && !r_ctl[Q_W-1].zero) |-> (r_rem[Q_W-1] < r_den[Q_W-1]))
        else $error("final remainder not below divisor");

    // a stalled pipe keeps its last stage
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ce |=> ($stable(r_vld[Q_W-1]) && $stable(r_q[Q_W-1])))
        else $error("divider moved during stall");

endmodule

// File: hw/rtl/gpcg_sqrt.sv
module gpcg_sqrt
    import gpcg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ce,
    input  logic               i_valid,
    input  t_ctl               i_ctl,
    input  logic [Q_W-1:0]     i_quot,
    output logic               o_valid,
    output t_ctl               o_ctl,
    output logic [ROOT_W-1:0]  o_root,
    output logic [ROOT_W-1:0]  o_lin
);

    // digit-by-digit integer square root, one root bit per stage
    logic               r_vld  [ROOT_W];
    t_ctl               r_ctl  [ROOT_W];
    logic [Q_W-1:0]     r_val  [ROOT_W];
    logic [SREM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0]  r_root [ROOT_W];
    logic [ROOT_W-1:0]  r_lin  [ROOT_W];

    for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
        logic               p_vld;
        t_ctl               p_ctl;
        logic [Q_W-1:0]     p_val;
        logic [SREM_W-1:0]  p_rem;
        logic [ROOT_W-1:0]  p_root, p_lin;
        logic [SREM_W+1:0]  cand, trial, diff;
        logic               ge;

        if (g == 0) begin : g_first
            assign p_vld  = i_valid;
            assign p_ctl  = i_ctl;
            assign p_val  = i_quot;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_lin  = i_quot[Q_W-1 -: ROOT_W];
        end else begin : g_next
            assign p_vld  = r_vld[g-1];
            assign p_ctl  = r_ctl[g-1];
            assign p_val  = r_val[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_lin  = r_lin[g-1];
        end

        assign cand  = {p_rem, p_val[Q_W-1 -: 2]};
        assign trial = {2'b00, p_root, 2'b01};
        assign ge    = (cand >= trial);
        assign diff  = cand - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_ce) begin
                r_vld[g] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_ctl[g]  <= p_ctl;
                r_lin[g]  <= p_lin;
                r_val[g]  <= {p_val[Q_W-3:0], 2'b00};
                r_rem[g]  <= ge ? diff[SREM_W-1:0] : cand[SREM_W-1:0];
                r_root[g] <= {p_root[ROOT_W-2:0], ge};
            end
        end
    end

    assign o_valid = r_vld[ROOT_W-1];
    assign o_ctl   = r_ctl[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_lin   = r_lin[ROOT_W-1];

endmodule

// File: hw/rtl/gpcg_blend.sv
module gpcg_blend
    import gpcg_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_ce,
    input  logic                i_valid,
    input  t_ctl                i_ctl,
    input  logic [ROOT_W-1:0]   i_root,
    input  logic [ROOT_W-1:0]   i_lin,
    input  logic [COLOR_W-1:0]  i_start,
    input  logic [COLOR_W-1:0]  i_end,
    output logic                o_valid,
    output logic [COLOR_W-1:0]  o_rgb
);

    // stage 1: final position with clamp and zero divisor
    logic [T_W-1:0]  t_sel;
    logic            r1_valid;
    logic [T_W-1:0]  r1_t;

    always_comb begin
        if (i_ctl.zero) begin
            t_sel = '0;
        end else if (i_ctl.sat) begin
            t_sel = T_ONE;
        end else if (i_ctl.radial) begin
            t_sel = {1'b0, i_root};
        end else begin
            t_sel = {1'b0, i_lin};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_ce) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r1_t <= t_sel;
        end
    end

    // stage 2: channel step times position; stage 3: add start, output register
    logic               r2_valid;
    logic signed [26:0] r2_prod [3];
    logic               r3_valid;
    logic [COLOR_W-1:0] r3_rgb;
    logic [COLOR_W-1:0] rgb;

    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [CH_W-1:0]     s, e;
        logic signed [8:0]   step;
        logic signed [26:0]  prod, acc;

        assign s    = i_start[COLOR_W-1-CH_W*c -: CH_W];
        assign e    = i_end[COLOR_W-1-CH_W*c -: CH_W];
        assign step = $signed({1'b0, e}) - $signed({1'b0, s});
        assign prod = step * $signed({1'b0, r1_t});
        assign acc  = $signed({3'b000, s, 16'h0000}) + r2_prod[c];
        assign rgb[CH_W*c +: CH_W] = acc[23:16];

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r2_prod[c] <= prod;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_ce) begin
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r3_rgb <= rgb;
        end
    end

    assign o_valid = r3_valid;
    assign o_rgb   = r3_rgb;

endmodule
